// ===== src/hq2u_pkg.sv =====
// Shared types, constants and the square-root step for the half-to-unit-quaternion block.
`default_nettype none
package hq2u_pkg;

	// binary16 field codes
	localparam logic [4:0]  HALF_EXP_MAX   = 5'h1F;
	localparam logic [4:0]  HALF_EXP_BIAS  = 5'd15;
	localparam logic [4:0]  HALF_SHIFT_TOP = 5'd14;

	// fixed-point limits
	localparam logic [14:0] Q15_MAX = 15'h7FFF;
	localparam logic [31:0] Q30_ONE = 32'h4000_0000;

	// square-root pipeline shape: two result bits per stage
	localparam int SQRT_BITS     = 16;
	localparam int SQRT_PER_STG  = 2;
	localparam int SQRT_STAGES   = SQRT_BITS / SQRT_PER_STG;

	// components that ride along with the w computation
	typedef struct packed {
		logic [15:0] quat_x;
		logic [15:0] quat_y;
		logic [15:0] quat_z;
		logic        range_flag;
	} side_t;

	// partial square root: remainder and root bits found so far
	typedef struct packed {
		logic [31:0] rem;
		logic [15:0] root;
	} sq_t;

	// Resolve one root bit by trial subtraction.
	function automatic sq_t sqrt_step(input sq_t a, input int unsigned b);
		logic [31:0] root_ext;
		logic [31:0] trial;
		sq_t         r;
		root_ext = {16'b0, a.root};
		trial    = (root_ext << (b + 1)) + (32'd1 << (2 * b));
		r        = a;
		if (a.rem >= trial) begin
			r.rem  = a.rem - trial;
			r.root = a.root | (16'd1 << b);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== src/hq2u_decode.sv =====
// Decode of one binary16 word into signed Q1.15 with saturation and a flag for NaN, infinity or saturation.
`default_nettype none
module hq2u_decode (
	input  wire logic [15:0]        half,
	output logic signed [15:0]      quat,
	output logic                    flag
);
	import hq2u_pkg::*;

	logic        sgn;
	logic [4:0]  expo;
	logic [9:0]  mant;
	logic [14:0] full_sh;
	logic [14:0] mag;
	logic [15:0] mag16;

	// split fields, pick the magnitude for each exponent class
	always_comb begin
		sgn     = half[15];
		expo    = half[14:10];
		mant    = half[9:0];
		full_sh = {1'b1, mant, 4'b0};
		flag    = 1'b0;
		if (expo == HALF_EXP_MAX) begin
			flag = 1'b1;
			mag  = (mant != 10'd0) ? 15'd0 : Q15_MAX;
		end else if (expo >= HALF_EXP_BIAS) begin
			flag = 1'b1;
			mag  = Q15_MAX;
		end else if (expo == 5'd0) begin
			// subnormal: mantissa * 2^-24 keeps only its top bit
			mag = {14'b0, mant[9]};
		end else begin
			mag = full_sh >> (HALF_SHIFT_TOP - expo);
		end
		mag16 = {1'b0, mag};
		quat  = sgn ? $signed(-mag16) : $signed(mag16);
	end

endmodule
`default_nettype wire

// ===== src/hq2u_sumsq.sv =====
// Squares, sum, clamp at one and the remainder 1.0 - sum (two pipeline stages).
`default_nettype none
module hq2u_sumsq (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_vld,
	input  wire hq2u_pkg::side_t in_side,
	output logic                out_vld,
	output hq2u_pkg::side_t     out_side,
	output logic [31:0]         out_rem
);
	import hq2u_pkg::*;

	logic [14:0] mag_x, mag_y, mag_z;
	logic [29:0] sq_x_s2, sq_y_s2, sq_z_s2;
	side_t       side_s2;
	logic        vld_s2;
	logic [31:0] sum;
	logic [31:0] sum_clamp;
	logic [31:0] rem_s3;
	side_t       side_s3;
	logic        vld_s3;

	// take magnitudes; no component is below -32767
	always_comb begin
		mag_x = in_side.quat_x[15] ? 15'(-in_side.quat_x) : in_side.quat_x[14:0];
		mag_y = in_side.quat_y[15] ? 15'(-in_side.quat_y) : in_side.quat_y[14:0];
		mag_z = in_side.quat_z[15] ? 15'(-in_side.quat_z) : in_side.quat_z[14:0];
	end

	// advance valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s2 <= in_vld;
			vld_s3 <= vld_s2;
		end
	end

	// stage 2: square each component
	always_ff @(posedge clk) begin
		sq_x_s2 <= mag_x * mag_x;
		sq_y_s2 <= mag_y * mag_y;
		sq_z_s2 <= mag_z * mag_z;
		side_s2 <= in_side;
	end

	// sum in Q2.30 and clamp at one
	always_comb begin
		sum       = {2'b0, sq_x_s2} + {2'b0, sq_y_s2} + {2'b0, sq_z_s2};
		sum_clamp = (sum > Q30_ONE) ? Q30_ONE : sum;
	end

	// stage 3: remainder left for w squared
	always_ff @(posedge clk) begin
		rem_s3  <= Q30_ONE - sum_clamp;
		side_s3 <= side_s2;
	end

	assign out_vld  = vld_s3;
	assign out_side = side_s3;
	assign out_rem  = rem_s3;

endmodule
`default_nettype wire

// ===== src/hq2u_isqrt.sv =====
// Pipelined integer square root, two root bits per stage, with side data carried along.
`default_nettype none
module hq2u_isqrt (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_vld,
	input  wire hq2u_pkg::side_t in_side,
	input  wire logic [31:0]     in_rem,
	output logic                 out_vld,
	output hq2u_pkg::side_t      out_side,
	output logic [15:0]          out_root
);
	import hq2u_pkg::*;

	logic  vld_s  [0:SQRT_STAGES];
	side_t side_s [0:SQRT_STAGES];
	sq_t   sq_s   [0:SQRT_STAGES];

	// stage inputs
	always_comb begin
		vld_s[0]       = in_vld;
		side_s[0]      = in_side;
		sq_s[0].rem    = in_rem;
		sq_s[0].root   = 16'd0;
	end

	for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
		localparam int unsigned BIT_HI = SQRT_BITS - 1 - SQRT_PER_STG * k;
		sq_t nxt;

		// resolve the upper then the lower bit of this pair
		always_comb begin
			nxt = sqrt_step(sqrt_step(sq_s[k], BIT_HI), BIT_HI - 1);
		end

		// advance valid
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		// hold partial root and side data
		always_ff @(posedge clk) begin
			sq_s[k+1]   <= nxt;
			side_s[k+1] <= side_s[k];
		end
	end

	assign out_vld  = vld_s[SQRT_STAGES];
	assign out_side = side_s[SQRT_STAGES];
	assign out_root = sq_s[SQRT_STAGES].root;

endmodule
`default_nettype wire

// ===== src/half_quaternion_to_unit_quaternion_top.sv =====
// Top level: half-precision quaternion vector in, unit quaternion in Q1.15 out.
//
// Usage:
//   Drive half_x, half_y, half_z (binary16 bit patterns) and raise start for one
//   cycle per beat. A beat is taken at each rising edge with start high and busy
//   low; busy stays low, so a new beat may enter on every cycle.
//   Each beat yields one result beat: done is high for exactly one cycle with
//   quat_x, quat_y, quat_z (signed Q1.15), quat_w (unsigned Q1.15, 0..32768) and
//   range_flag valid in that same cycle.
// Pipeline and throughput:
//   A decode register, one squaring stage, one sum/clamp stage, then eight
//   square-root stages that each settle two bits of w. One beat per cycle.
// Reset:
//   arst_n low clears every valid bit at once; beats in flight are dropped and
//   done stays low until new beats work through.
// Back pressure:
//   The receiver takes every result as it appears; there is no stall path.
`default_nettype none
module half_quaternion_to_unit_quaternion_top (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [15:0]        half_x,
	input  wire logic [15:0]        half_y,
	input  wire logic [15:0]        half_z,
	output logic                    done,
	output logic signed [15:0]      quat_x,
	output logic signed [15:0]      quat_y,
	output logic signed [15:0]      quat_z,
	output logic [15:0]             quat_w,
	output logic                    range_flag
);
	import hq2u_pkg::*;

	logic signed [15:0] dec_x, dec_y, dec_z;
	logic               flg_x, flg_y, flg_z;
	logic               vld_s1;
	side_t              side_s1;
	logic               sum_vld;
	side_t              sum_side;
	logic [31:0]        sum_rem;
	logic               rt_vld;
	side_t              rt_side;
	logic [15:0]        rt_root;

	// the pipeline never stalls
	assign busy = 1'b0;

	hq2u_decode u_dec_x (.half(half_x), .quat(dec_x), .flag(flg_x));
	hq2u_decode u_dec_y (.half(half_y), .quat(dec_y), .flag(flg_y));
	hq2u_decode u_dec_z (.half(half_z), .quat(dec_z), .flag(flg_z));

	// stage 1: register the decoded components
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		side_s1.quat_x     <= dec_x;
		side_s1.quat_y     <= dec_y;
		side_s1.quat_z     <= dec_z;
		side_s1.range_flag <= flg_x | flg_y | flg_z;
	end

	hq2u_sumsq u_sumsq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s1),
		.in_side  (side_s1),
		.out_vld  (sum_vld),
		.out_side (sum_side),
		.out_rem  (sum_rem)
	);

	hq2u_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (sum_vld),
		.in_side  (sum_side),
		.in_rem   (sum_rem),
		.out_vld  (rt_vld),
		.out_side (rt_side),
		.out_root (rt_root)
	);

	// drive the result beat
	assign done       = rt_vld;
	assign quat_x     = $signed(rt_side.quat_x);
	assign quat_y     = $signed(rt_side.quat_y);
	assign quat_z     = $signed(rt_side.quat_z);
	assign quat_w     = rt_root;
	assign range_flag = rt_side.range_flag;

endmodule
`default_nettype wire

// ===== dv/half_quaternion_to_unit_quaternion_top_tb.sv =====
// Self-checking testbench for the half-precision to unit-quaternion block.
`default_nettype none
module half_quaternion_to_unit_quaternion_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import hq2u_pkg::*;

	localparam int ITEM_COUNT  = 1100;
	localparam int LATENCY     = 11;
	localparam int MAX_GAP     = 13;
	localparam int CYCLE_LIMIT = 200000;
	localparam int MANT_BITS   = 10;

	// one expected output beat
	typedef struct {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
		logic [15:0]        w;
		logic               flag;
	} unit_quat_t;

	// expected-result store and predictor
	class quat_scoreboard;
		unit_quat_t expected_quats[$];
		int         mismatches;

		task report(input string msg);
			$display("MISMATCH: %s", msg);
			mismatches++;
		endtask

		// truncate toward zero into Q1.15, saturate at one, NaN goes to zero
		function logic signed [15:0] decode_half_q15(input logic [15:0] h, inout logic flag);
			logic [4:0] expo;
			logic [9:0] mant;
			int         mag;
			expo = h[14:10];
			mant = h[9:0];
			if (expo == HALF_EXP_MAX) begin
				flag = 1'b1;
				mag  = (mant != 0) ? 0 : int'(Q15_MAX);
			end else if (expo >= HALF_EXP_BIAS) begin
				flag = 1'b1;
				mag  = int'(Q15_MAX);
			end else if (expo == 0) begin
				mag = int'(mant) >> (MANT_BITS - 1);
			end else if (expo >= MANT_BITS) begin
				mag = ((1 << MANT_BITS) + int'(mant)) << (int'(expo) - MANT_BITS);
			end else begin
				mag = ((1 << MANT_BITS) + int'(mant)) >> (MANT_BITS - int'(expo));
			end
			return h[15] ? 16'(-mag) : 16'(mag);
		endfunction

		// bitwise floor square root, 16 result bits
		function logic [15:0] floor_sqrt(input longint unsigned v);
			longint unsigned root;
			longint unsigned trial;
			root = 0;
			for (int b = 15; b >= 0; b--) begin
				trial = root | (64'd1 << b);
				if (trial * trial <= v)
					root = trial;
			end
			return root[15:0];
		endfunction

		function unit_quat_t predict_unit_quat(input logic [15:0] hx, hy, hz);
			unit_quat_t      q;
			longint unsigned sum;
			longint unsigned mag;
			logic            flag;
			flag = 1'b0;
			q.x  = decode_half_q15(hx, flag);
			q.y  = decode_half_q15(hy, flag);
			q.z  = decode_half_q15(hz, flag);
			sum  = 0;
			mag  = (q.x < 0) ? longint'(-q.x) : longint'(q.x);
			sum += mag * mag;
			mag  = (q.y < 0) ? longint'(-q.y) : longint'(q.y);
			sum += mag * mag;
			mag  = (q.z < 0) ? longint'(-q.z) : longint'(q.z);
			sum += mag * mag;
			// clamp the sum of squares at one
			if (sum > longint'(Q30_ONE))
				sum = longint'(Q30_ONE);
			q.w    = floor_sqrt(longint'(Q30_ONE) - sum);
			q.flag = flag;
			return q;
		endfunction

		function void note_beat(input logic [15:0] hx, hy, hz);
			expected_quats.push_back(predict_unit_quat(hx, hy, hz));
		endfunction

		task check_result(input logic signed [15:0] x, y, z, input logic [15:0] w,
				input logic flag);
			unit_quat_t e;
			if (expected_quats.size() == 0) begin
				report("result beat with nothing pending");
			end else begin
				e = expected_quats.pop_front();
				if (x !== e.x)
					report($sformatf("quat_x got %0d expected %0d", x, e.x));
				if (y !== e.y)
					report($sformatf("quat_y got %0d expected %0d", y, e.y));
				if (z !== e.z)
					report($sformatf("quat_z got %0d expected %0d", z, e.z));
				if (w !== e.w)
					report($sformatf("quat_w got %0d expected %0d", w, e.w));
				if (flag !== e.flag)
					report($sformatf("range_flag got %b expected %b", flag, e.flag));
			end
		endtask
	endclass

	logic               clk;
	logic               arst_n = 1'b0;
	logic               start  = 1'b0;
	logic               busy;
	logic [15:0]        half_x = '0;
	logic [15:0]        half_y = '0;
	logic [15:0]        half_z = '0;
	logic               done;
	logic signed [15:0] quat_x;
	logic signed [15:0] quat_y;
	logic signed [15:0] quat_z;
	logic [15:0]        quat_w;
	logic               range_flag;
	int                 cycle_count = 0;

	quat_scoreboard quat_sb = new();

	half_quaternion_to_unit_quaternion_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.half_x     (half_x),
		.half_y     (half_y),
		.half_z     (half_z),
		.done       (done),
		.quat_x     (quat_x),
		.quat_y     (quat_y),
		.quat_z     (quat_z),
		.quat_w     (quat_w),
		.range_flag (range_flag)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// end the run if it hangs
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAILURE");
		$finish;
	end

	// check every result beat at the edge that ends its strobe cycle
	always @(posedge clk) begin
		if (arst_n && done)
			quat_sb.check_result(quat_x, quat_y, quat_z, quat_w, range_flag);
	end

	// present one beat and hold it until taken
	task automatic send_beat(input logic [15:0] hx, hy, hz);
		start  <= 1'b1;
		half_x <= hx;
		half_y <= hy;
		half_z <= hz;
		do @(posedge clk); while (busy);
		quat_sb.note_beat(hx, hy, hz);
	endtask

	task automatic idle_cycles(input int n);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// draw one component: mostly in range, some saturating, NaN or raw noise
	function automatic logic [15:0] draw_half();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 2)
			return 16'($urandom);
		if (pick == 2) begin
			case ($urandom_range(0, 2))
				0: return {1'($urandom), HALF_EXP_MAX, 10'd0};
				1: return {1'($urandom), HALF_EXP_MAX, 10'($urandom_range(1, 1023))};
				default: return {1'($urandom), 5'($urandom_range(15, 30)), 10'($urandom)};
			endcase
		end
		if (pick < 5)
			return {1'($urandom), 5'($urandom_range(10, 14)), 10'($urandom)};
		return {1'($urandom), 5'($urandom_range(0, 14)), 10'($urandom)};
	endfunction

	logic [47:0] directed_beats[] = '{
		{16'h0000, 16'h0000, 16'h0000},  // all zero, w at its top
		{16'h8000, 16'h8000, 16'h8000},  // negative zeros
		{16'h0001, 16'h03FF, 16'h83FF},  // subnormals
		{16'h0400, 16'h0401, 16'h8401},  // smallest normals
		{16'h27FF, 16'h2800, 16'hA800},  // exponent around the shift pivot
		{16'h3BFF, 16'hBBFF, 16'h0000},  // largest value below one
		{16'h3800, 16'h3800, 16'h3800},  // exact root
		{16'h3A00, 16'h3A00, 16'h3A00},  // sum above one, w clamps to zero
		{16'h3C00, 16'h0000, 16'h0000},  // exactly one saturates
		{16'hBC00, 16'h0000, 16'h0000},
		{16'h7BFF, 16'hFBFF, 16'h0000},  // largest finite
		{16'h7C00, 16'h0000, 16'h0000},  // infinities
		{16'h0000, 16'hFC00, 16'h0000},
		{16'h0000, 16'h0000, 16'h7E00},  // NaNs
		{16'hFFFF, 16'h7C01, 16'h0000},
		{16'h4000, 16'h3400, 16'h0100},
		{16'h3555, 16'hB2AA, 16'h2FFF},
		{16'h5555, 16'hAAAA, 16'h0F0F},
		{16'hFFFF, 16'hFFFF, 16'hFFFF},
		{16'h3B00, 16'h3100, 16'hB100},
		{16'h2E66, 16'hAE66, 16'h3A9A}
	};

	initial begin
		bit burst;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners
		foreach (directed_beats[i]) begin
			send_beat(directed_beats[i][47:32], directed_beats[i][31:16],
				directed_beats[i][15:0]);
			idle_cycles((i % 3 == 0) ? 0 : $urandom_range(0, MAX_GAP));
		end

		// random beats, in stretches of 64 that are either back-to-back or gappy
		burst = 1'b0;
		for (int i = 0; i < ITEM_COUNT; i++) begin
			if (i % 64 == 0)
				burst = ($urandom_range(0, 2) == 0);
			send_beat(draw_half(), draw_half(), draw_half());
			idle_cycles(burst ? 0 : $urandom_range(0, MAX_GAP));
		end
		start <= 1'b0;

		// drain, then watch for stray beats
		while (quat_sb.expected_quats.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);

		if (quat_sb.mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
`default_nettype wire

// ===== sim.f =====
src/hq2u_pkg.sv
src/hq2u_decode.sv
src/hq2u_sumsq.sv
src/hq2u_isqrt.sv
src/half_quaternion_to_unit_quaternion_top.sv
dv/half_quaternion_to_unit_quaternion_top_tb.sv
